/* rtl/deq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants and codes for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH      = 1024;
  localparam int ELEM_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);

  localparam int ACT_W   = 3;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int DATA_W  = 32;
  localparam int FILL_W  = 11;

  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PEEK_FRONT = 3'd4;
  localparam logic [ACT_W-1:0] ACT_PEEK_BACK  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef logic [AW-1:0]         addr_t;
  typedef logic [CW-1:0]         count_t;
  typedef logic [ELEM_WIDTH-1:0] elem_t;

  // Front index plus offset, wrapped into the ring (offset < DEPTH).
  function automatic addr_t ring_add(input addr_t base, input count_t offset);
    logic [CW:0] sum;
    begin
      sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, offset};
      if (sum >= (CW + 1)'(DEPTH)) begin
        sum = sum - (CW + 1)'(DEPTH);
      end
      return sum[AW-1:0];
    end
  endfunction

endpackage

/* rtl/deq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_in_if / deq_out_if
// Valid/ready channels for requests and results of the queue.
// ----------------------------------------------------------------------------
interface deq_in_if;
  logic                         valid;
  logic                         ready;
  logic [deq_pkg::ACT_W-1:0]    action;
  logic [deq_pkg::VAL_W-1:0]    value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface deq_out_if;
  logic                         valid;
  logic                         ready;
  logic [deq_pkg::STAT_W-1:0]   status;
  logic [deq_pkg::DATA_W-1:0]   data;
  logic [deq_pkg::FILL_W-1:0]   fill_count;

  modport source (output valid, output status, output data, output fill_count,
                  input ready);
  modport sink   (input valid, input status, input data, input fill_count,
                  output ready);
endinterface

/* rtl/double_ended_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Fixed-capacity deque kept as a ring in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one request item per handshake: action (push back/front,
//              pop front/back, peek front/back) and the value to push.
//   out_chan : exactly one result item per request: status, data read
//              (zero on pushes and refusals) and fill count after the step.
// Timing: a result is valid in the cycle after its request is taken; the
//   memory read issued at acceptance lands in the result register.
// Throughput: one item per cycle while out_chan takes results. Ring pointers
//   update at acceptance, so the next request sees them at once; a write
//   lands in the memory before any later read of that entry.
// Stall: while a result waits, in_chan.ready follows out_chan.ready; the
//   memory read register holds because no new read is issued.
// Reset: front index and count clear, no result pending. The memory is
//   not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic       clk,
  input  logic       rst_n,
  deq_in_if.sink     in_chan,
  deq_out_if.source  out_chan
);

  deq_pkg::elem_t mem [deq_pkg::DEPTH];

  deq_pkg::addr_t  front_r, front_nxt;
  deq_pkg::count_t count_r, count_nxt;

  logic                         res_valid_r;
  logic [deq_pkg::STAT_W-1:0]   res_status_r, res_status_nxt;
  logic                         res_rd_r, res_rd_nxt;
  deq_pkg::count_t              res_fill_r;
  deq_pkg::elem_t               rd_q_r;

  logic           in_acc;
  logic           wr_en, rd_en;
  deq_pkg::addr_t wr_addr, rd_addr, front_dec, back_addr;
  deq_pkg::elem_t wr_val;
  logic           is_full, is_empty;

  assign in_chan.ready = !res_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign is_full   = (count_r == deq_pkg::count_t'(deq_pkg::DEPTH));
  assign is_empty  = (count_r == '0);
  assign front_dec = (front_r == '0) ? deq_pkg::addr_t'(deq_pkg::DEPTH - 1)
                                     : front_r - 1'b1;
  assign back_addr = deq_pkg::ring_add(front_r, count_r - 1'b1);
  assign wr_val    = deq_pkg::elem_t'(in_chan.value);

  always_comb begin
    front_nxt      = front_r;
    count_nxt      = count_r;
    wr_en          = 1'b0;
    wr_addr        = deq_pkg::ring_add(front_r, count_r);
    rd_en          = 1'b0;
    rd_addr        = front_r;
    res_status_nxt = deq_pkg::ST_OK;
    res_rd_nxt     = 1'b0;
    case (in_chan.action)
      deq_pkg::ACT_PUSH_BACK: begin
        if (is_full) begin
          res_status_nxt = deq_pkg::ST_FULL;
        end else begin
          wr_en     = in_acc;
          count_nxt = count_r + 1'b1;
        end
      end
      deq_pkg::ACT_PUSH_FRONT: begin
        if (is_full) begin
          res_status_nxt = deq_pkg::ST_FULL;
        end else begin
          wr_en     = in_acc;
          wr_addr   = front_dec;
          front_nxt = front_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      deq_pkg::ACT_POP_FRONT: begin
        if (is_empty) begin
          res_status_nxt = deq_pkg::ST_EMPTY;
        end else begin
          rd_en      = in_acc;
          res_rd_nxt = 1'b1;
          front_nxt  = deq_pkg::ring_add(front_r, deq_pkg::count_t'(1));
          count_nxt  = count_r - 1'b1;
        end
      end
      deq_pkg::ACT_POP_BACK: begin
        if (is_empty) begin
          res_status_nxt = deq_pkg::ST_EMPTY;
        end else begin
          rd_en      = in_acc;
          rd_addr    = back_addr;
          res_rd_nxt = 1'b1;
          count_nxt  = count_r - 1'b1;
        end
      end
      deq_pkg::ACT_PEEK_FRONT: begin
        if (is_empty) begin
          res_status_nxt = deq_pkg::ST_EMPTY;
        end else begin
          rd_en      = in_acc;
          res_rd_nxt = 1'b1;
        end
      end
      deq_pkg::ACT_PEEK_BACK: begin
        if (is_empty) begin
          res_status_nxt = deq_pkg::ST_EMPTY;
        end else begin
          rd_en      = in_acc;
          rd_addr    = back_addr;
          res_rd_nxt = 1'b1;
        end
      end
      default: begin
        // unused codes: no-op, ok status
      end
    endcase
  end

  // element store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_val;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        front_r     <= front_nxt;
        count_r     <= count_nxt;
        res_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_status_r <= res_status_nxt;
      res_rd_r     <= res_rd_nxt;
      res_fill_r   <= count_nxt;
    end
  end

  assign out_chan.valid      = res_valid_r;
  assign out_chan.status     = res_status_r;
  assign out_chan.data       = res_rd_r ? deq_pkg::DATA_W'(rd_q_r) : '0;
  assign out_chan.fill_count = deq_pkg::FILL_W'(res_fill_r);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= deq_pkg::count_t'(deq_pkg::DEPTH))
    else $error("fill count exceeds capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> res_valid_r)
    else $error("accepted item produced no result");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_status_r == deq_pkg::ST_FULL) |->
      (res_fill_r == deq_pkg::count_t'(deq_pkg::DEPTH) && !res_rd_r))
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_status_r == deq_pkg::ST_EMPTY) |->
      (res_fill_r == '0 && !res_rd_r))
    else $error("empty status with stored items");

  a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("read and write issued by one item");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for double_ended_queue. A shadow deque predicts status,
// data and fill count for every accepted request; each result item is checked
// in order against it. Covers empty and full refusals, spare action codes,
// pointer wrap, random mixes under varied idling, and a long output stall.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [deq_pkg::ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [deq_pkg::ACT_W-1:0] ACT_SPARE_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PRINT_CAP   = 30;

  typedef struct packed {
    logic [deq_pkg::STAT_W-1:0] status;
    logic [deq_pkg::DATA_W-1:0] data;
    logic [deq_pkg::FILL_W-1:0] fill;
  } deq_result_t;

  logic clk = 1'b0;
  logic rst_n;

  deq_in_if  in_chan ();
  deq_out_if out_chan ();

  double_ended_queue u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // shadow copy of the ring
  deq_pkg::elem_t shadow_mem [deq_pkg::DEPTH];
  int unsigned    shadow_front;
  int unsigned    shadow_count;

  deq_result_t pending_results [$];
  int unsigned mismatch_count;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_budget;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("double_ended_queue: mismatch");
      $finish;
    end
  end

  // receiver: long hold-off when requested, otherwise random idling
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (stall_budget > 0) begin
      out_chan.ready <= 1'b0;
      stall_budget--;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    deq_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result item with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_chan.status !== want.status) begin
          report_mismatch($sformatf("status got %0d want %0d", out_chan.status, want.status));
        end
        if (out_chan.data !== want.data) begin
          report_mismatch($sformatf("data got %h want %h", out_chan.data, want.data));
        end
        if (out_chan.fill_count !== want.fill) begin
          report_mismatch($sformatf("fill got %0d want %0d", out_chan.fill_count,
                                    want.fill));
        end
      end
    end
  end

  function automatic int unsigned ring_slot(input int unsigned offset);
    return (shadow_front + offset) % deq_pkg::DEPTH;
  endfunction

  // update the shadow deque and queue the result this request must give
  function automatic void apply_action(input logic [deq_pkg::ACT_W-1:0] act,
                                       input logic [deq_pkg::VAL_W-1:0] val);
    deq_result_t res;
    res.status = deq_pkg::ST_OK;
    res.data   = '0;
    case (act)
      deq_pkg::ACT_PUSH_BACK, deq_pkg::ACT_PUSH_FRONT: begin
        if (shadow_count == deq_pkg::DEPTH) begin
          res.status = deq_pkg::ST_FULL;
        end else if (act == deq_pkg::ACT_PUSH_BACK) begin
          shadow_mem[ring_slot(shadow_count)] = deq_pkg::elem_t'(val);
          shadow_count++;
        end else begin
          shadow_front = ring_slot(deq_pkg::DEPTH - 1);
          shadow_mem[shadow_front] = deq_pkg::elem_t'(val);
          shadow_count++;
        end
      end
      deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK,
      deq_pkg::ACT_PEEK_FRONT, deq_pkg::ACT_PEEK_BACK: begin
        if (shadow_count == 0) begin
          res.status = deq_pkg::ST_EMPTY;
        end else if (act == deq_pkg::ACT_POP_FRONT || act == deq_pkg::ACT_PEEK_FRONT) begin
          res.data = deq_pkg::DATA_W'(shadow_mem[ring_slot(0)]);
          if (act == deq_pkg::ACT_POP_FRONT) begin
            shadow_front = ring_slot(1);
            shadow_count--;
          end
        end else begin
          res.data = deq_pkg::DATA_W'(shadow_mem[ring_slot(shadow_count - 1)]);
          if (act == deq_pkg::ACT_POP_BACK) begin
            shadow_count--;
          end
        end
      end
      default: ;  // spare codes do nothing
    endcase
    res.fill = deq_pkg::FILL_W'(shadow_count);
    pending_results.push_back(res);
  endfunction

  // valid stays high after acceptance; the next call replaces the item or lowers it, drain_results lowers it
  task automatic send_item(input logic [deq_pkg::ACT_W-1:0] act,
                           input logic [deq_pkg::VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.action <= act;
    in_chan.value  <= val;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    apply_action(act, val);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [deq_pkg::VAL_W-1:0] rand_value();
    int unsigned roll;
    roll = $urandom_range(15);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [deq_pkg::ACT_W-1:0] pick_action(input int unsigned push_pct);
    if ($urandom_range(99) < 3) return $urandom_range(1) ? ACT_SPARE_LO : ACT_SPARE_HI;
    if ($urandom_range(99) < push_pct) begin
      return $urandom_range(1) ? deq_pkg::ACT_PUSH_FRONT : deq_pkg::ACT_PUSH_BACK;
    end
    case ($urandom_range(5))
      0: return deq_pkg::ACT_PEEK_FRONT;
      1: return deq_pkg::ACT_PEEK_BACK;
      2, 3: return deq_pkg::ACT_POP_FRONT;
      default: return deq_pkg::ACT_POP_BACK;
    endcase
  endfunction

  task automatic test_directed();
    // refusals and spare codes on an empty queue
    send_item(deq_pkg::ACT_POP_FRONT, 32'hFFFF_FFFF);
    send_item(deq_pkg::ACT_POP_BACK, 32'h0);
    send_item(deq_pkg::ACT_PEEK_FRONT, 32'h1234_5678);
    send_item(deq_pkg::ACT_PEEK_BACK, 32'h0);
    send_item(ACT_SPARE_LO, 32'hDEAD_BEEF);
    send_item(ACT_SPARE_HI, 32'hFFFF_FFFF);
    // push front from index zero wraps to the top of the ring
    send_item(deq_pkg::ACT_PUSH_BACK, 32'h0000_0000);
    send_item(deq_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF);
    send_item(deq_pkg::ACT_PUSH_BACK, 32'hAAAA_AAAA);
    send_item(deq_pkg::ACT_PUSH_FRONT, 32'h5555_5555);
    send_item(deq_pkg::ACT_PEEK_FRONT, 32'h0);
    send_item(deq_pkg::ACT_PEEK_BACK, 32'h0);
    send_item(ACT_SPARE_HI, 32'h0);
    send_item(deq_pkg::ACT_POP_BACK, 32'h0);
    send_item(deq_pkg::ACT_POP_FRONT, 32'h0);
    send_item(deq_pkg::ACT_POP_BACK, 32'h0);
    send_item(deq_pkg::ACT_POP_FRONT, 32'h0);
    send_item(deq_pkg::ACT_POP_FRONT, 32'h0);
    drain_results();
  endtask

  // fill to capacity from both ends, then try pushes and peeks on a full queue;
  // the queue is left full for the random mixes that follow
  task automatic test_fill_to_full();
    for (int i = 0; i < deq_pkg::DEPTH; i++) begin
      send_item(i[0] ? deq_pkg::ACT_PUSH_FRONT : deq_pkg::ACT_PUSH_BACK, rand_value());
    end
    send_item(deq_pkg::ACT_PUSH_BACK, 32'hFFFF_FFFF);
    send_item(deq_pkg::ACT_PUSH_FRONT, 32'h0);
    send_item(deq_pkg::ACT_PEEK_FRONT, 32'h0);
    send_item(deq_pkg::ACT_PEEK_BACK, 32'h0);
    send_item(ACT_SPARE_LO, rand_value());
    drain_results();
  endtask

  // random walk; the push bias changes per segment so the fill swings
  task automatic test_random_mix(input int unsigned n_items);
    int unsigned done_items;
    int unsigned push_pct;
    logic [deq_pkg::ACT_W-1:0] act;
    done_items = 0;
    push_pct   = 50;
    while (done_items < n_items) begin
      if (done_items % 10 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 15;
          1: push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      act = pick_action(push_pct);
      send_item(act, rand_value());
      if (act != ACT_SPARE_LO && act != ACT_SPARE_HI) done_items++;
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    for (int i = 0; i < 5; i++) send_item(deq_pkg::ACT_POP_BACK, rand_value());
    // hold the output off; the sender keeps offering until the input stalls
    stall_budget = 400;
    for (int i = 0; i < 25; i++) send_item(pick_action(50), rand_value());
    // sender pauses until every result is back
    drain_results();
    for (int i = 0; i < 5; i++) send_item(pick_action(40), rand_value());
    drain_results();
  endtask

  initial begin
    mismatch_count = 0;
    stall_budget   = 0;
    shadow_front   = 0;
    shadow_count   = 0;
    send_idle_pct  = 34;
    recv_idle_pct  = 69;
    rst_n          <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.action <= deq_pkg::ACT_PUSH_BACK;
    in_chan.value  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_to_full();

    send_idle_pct = 69;
    recv_idle_pct = 34;
    test_random_mix(25);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(25);
    test_backpressure();

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("double_ended_queue: match");
    end else begin
      $display("double_ended_queue: mismatch");
    end
    $finish;
  end

endmodule
